// File: rtl/owm_pkg.sv
// ============================================================================
// owm_pkg: shared types and constants of the one-wire bus master
// Item and result layouts, command and status codes, register map and
// reset values of the timing registers.
// ============================================================================
package owm_pkg;

    // Width of the tick counter; timing limits saturate at its all-ones value
    localparam int TICK_COUNT_WIDTH = 12;

    localparam int REG_W     = 12;
    localparam int NUM_REGS  = 8;
    localparam int REG_IDX_W = $clog2(NUM_REGS);
    localparam int ADDR_W    = REG_IDX_W + 2;
    localparam int APB_W     = 32;

    // Compare width: covers a register, the counter plus one, and a sum of two
    localparam int CMP_W = ((TICK_COUNT_WIDTH > REG_W) ? TICK_COUNT_WIDTH : REG_W) + 1;
    localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((1 << TICK_COUNT_WIDTH) - 1);

    localparam int KIND_W   = 3;
    localparam int BITS_W   = 5;
    localparam int SHIFT_W  = 16;
    localparam int STATUS_W = 2;

    // Command kinds
    localparam logic [KIND_W-1:0] KIND_TICK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RESET  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ8  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ16 = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_PRESENCE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STUCK_LOW   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BUSY        = 2'd3;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_RESET_LOW   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_PRES_SAMPLE = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_PRES_END    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_WR1_LOW     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WR0_LOW     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_RD_LOW      = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_RD_SAMPLE   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SLOT        = 3'd7;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_regs_t;

    // Listed from index 7 down to index 0
    localparam cfg_regs_t REG_RESET_VALS = {
        12'd62, 12'd10, 12'd5, 12'd60, 12'd5, 12'd300, 12'd80, 12'd500
    };

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              line_level;
        logic [7:0]        data_byte;
        logic              hold_high_after;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SHIFT_W-1:0]  read_data;
        logic                done_res;
        logic                busy_res;
        logic                drive_high;
        logic                drive_low;
    } result_t;

endpackage

// File: rtl/owm_cfg.sv
// ============================================================================
// owm_cfg: timing register file
// APB write and read of the eight timing registers; reset loads defaults.
// ============================================================================
module owm_cfg (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [owm_pkg::ADDR_W-1:0] paddr,
    input  logic [owm_pkg::APB_W-1:0]  pwdata,
    output logic [owm_pkg::APB_W-1:0]  prdata,
    output owm_pkg::cfg_regs_t         cfg
);

    owm_pkg::cfg_regs_t             regs_reg;
    logic [owm_pkg::REG_IDX_W-1:0]  idx;
    logic                           wr_en;

    assign idx   = paddr[owm_pkg::ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= owm_pkg::REG_RESET_VALS;
        end
        else if (wr_en)
        begin
            regs_reg[idx] <= pwdata[owm_pkg::REG_W-1:0];
        end
    end

    assign prdata = owm_pkg::APB_W'(regs_reg[idx]);
    assign cfg    = regs_reg;

endmodule

// File: rtl/owm_core.sv
// ============================================================================
// owm_core: bus sequencer
// Holds the command state and computes, in one pass, the next state and the
// line drive and result of one item.
// ============================================================================
module owm_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  owm_pkg::item_t       item,
    input  owm_pkg::cfg_regs_t   cfg,
    output owm_pkg::result_t     res
);

    localparam int TW = owm_pkg::TICK_COUNT_WIDTH;
    localparam int CW = owm_pkg::CMP_W;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_END,
        PH_WRITE,
        PH_READ8,
        PH_READ16
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [TW-1:0]                   tick_reg, tick_next, tick_inc;
    logic [owm_pkg::BITS_W-1:0]      bits_reg, bits_next, bits_dec;
    logic [owm_pkg::SHIFT_W-1:0]     shift_reg, shift_next, shift_smp;
    logic [owm_pkg::STATUS_W-1:0]    last_status_reg, last_status_next, status_out;
    logic                            strong_reg, strong_next;
    logic                            done;
    logic [owm_pkg::SHIFT_W-1:0]     rd;
    logic                            is_cmd;
    logic [CW-1:0]                   tc_plus1;
    logic                            reach_rst, reach_pres, reach_end, reach_slot;
    logic [CW-1:0]                   slot_lim, slot_last, smp_sum, smp_pos;
    logic [owm_pkg::REG_W-1:0]       low_time;
    logic                            drv_low, drv_high;

    function automatic logic [CW-1:0] limit_of(input logic [owm_pkg::REG_W-1:0] r);
        logic [CW-1:0] r_ext;
        r_ext = CW'(r);
        return (r_ext > owm_pkg::CNT_MAX) ? owm_pkg::CNT_MAX : r_ext;
    endfunction

    assign is_cmd   = (item.kind >= owm_pkg::KIND_RESET) && (item.kind <= owm_pkg::KIND_READ16);
    assign tc_plus1 = CW'(tick_reg) + CW'(1);
    assign tick_inc = (&tick_reg) ? tick_reg : tick_reg + TW'(1);
    assign bits_dec = (bits_reg != '0) ? bits_reg - owm_pkg::BITS_W'(1) : '0;

    assign reach_rst  = tc_plus1 >= limit_of(cfg[owm_pkg::REG_RESET_LOW]);
    assign reach_pres = tc_plus1 >= limit_of(cfg[owm_pkg::REG_PRES_SAMPLE]);
    assign reach_end  = tc_plus1 >= limit_of(cfg[owm_pkg::REG_PRES_END]);
    assign reach_slot = tc_plus1 >= limit_of(cfg[owm_pkg::REG_SLOT]);

    // Read sample point, clamped to the last tick of the slot
    assign slot_lim  = limit_of(cfg[owm_pkg::REG_SLOT]);
    assign slot_last = (slot_lim != '0) ? slot_lim - CW'(1) : '0;
    assign smp_sum   = CW'(cfg[owm_pkg::REG_RD_LOW]) + CW'(cfg[owm_pkg::REG_RD_SAMPLE]);
    assign smp_pos   = (smp_sum > slot_last) ? slot_last : smp_sum;
    assign shift_smp = ((phase_reg != PH_WRITE) && (CW'(tick_reg) == smp_pos))
                       ? {item.line_level, shift_reg[owm_pkg::SHIFT_W-1:1]} : shift_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        bits_next   = bits_reg;
        shift_next  = shift_reg;
        strong_next = strong_reg;
        status_out  = last_status_reg;
        done        = 1'b0;
        rd          = '0;

        if (is_cmd)
        begin
            if (phase_reg != PH_IDLE)
            begin
                status_out = owm_pkg::ST_BUSY;
            end
            else
            begin
                strong_next = 1'b0;
                tick_next   = '0;
                shift_next  = '0;
                bits_next   = '0;
                case (item.kind)
                    owm_pkg::KIND_RESET:
                    begin
                        phase_next = PH_RST_LOW;
                    end
                    owm_pkg::KIND_WRITE:
                    begin
                        phase_next  = PH_WRITE;
                        shift_next  = owm_pkg::SHIFT_W'(item.data_byte);
                        bits_next   = owm_pkg::BITS_W'(8);
                        strong_next = item.hold_high_after;
                    end
                    owm_pkg::KIND_READ8:
                    begin
                        phase_next = PH_READ8;
                        bits_next  = owm_pkg::BITS_W'(8);
                    end
                    default:
                    begin
                        phase_next = PH_READ16;
                        bits_next  = owm_pkg::BITS_W'(16);
                    end
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                PH_RST_LOW:
                begin
                    if (reach_rst)
                    begin
                        phase_next = PH_RST_WAIT;
                        tick_next  = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                PH_RST_WAIT:
                begin
                    if (reach_pres)
                    begin
                        if (item.line_level)
                        begin
                            phase_next = PH_IDLE;
                            done       = 1'b1;
                            status_out = owm_pkg::ST_NO_PRESENCE;
                        end
                        else
                        begin
                            phase_next = PH_RST_END;
                            tick_next  = '0;
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                PH_RST_END:
                begin
                    if (reach_end)
                    begin
                        phase_next = PH_IDLE;
                        done       = 1'b1;
                        status_out = item.line_level ? owm_pkg::ST_OK : owm_pkg::ST_STUCK_LOW;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                PH_WRITE, PH_READ8, PH_READ16:
                begin
                    shift_next = shift_smp;
                    if (reach_slot)
                    begin
                        if (phase_reg == PH_WRITE)
                        begin
                            shift_next = shift_smp >> 1;
                        end
                        bits_next = bits_dec;
                        tick_next = '0;
                        if (bits_dec == '0)
                        begin
                            done       = 1'b1;
                            status_out = owm_pkg::ST_OK;
                            phase_next = PH_IDLE;
                            if (phase_reg == PH_READ8)
                            begin
                                rd = {8'h00, shift_smp[owm_pkg::SHIFT_W-1:8]};
                            end
                            else if (phase_reg == PH_READ16)
                            begin
                                rd = shift_smp;
                            end
                        end
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    assign last_status_next = done ? status_out : last_status_reg;

    // Drive for the coming tick interval, from the updated state
    assign low_time = shift_next[0] ? cfg[owm_pkg::REG_WR1_LOW] : cfg[owm_pkg::REG_WR0_LOW];

    always_comb
    begin
        drv_low  = 1'b0;
        drv_high = 1'b0;
        case (phase_next)
            PH_IDLE:
            begin
                drv_high = strong_next;
            end
            PH_RST_LOW:
            begin
                drv_low = 1'b1;
            end
            PH_WRITE:
            begin
                if (tick_next == '0)
                begin
                    drv_high = 1'b1;
                end
                else
                begin
                    drv_low = CW'(tick_next) <= CW'(low_time);
                end
            end
            PH_READ8, PH_READ16:
            begin
                drv_low = (tick_next != '0)
                          && (CW'(tick_next) <= CW'(cfg[owm_pkg::REG_RD_LOW]));
            end
            default:
            begin
                drv_low = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            tick_reg        <= '0;
            bits_reg        <= '0;
            shift_reg       <= '0;
            last_status_reg <= owm_pkg::ST_OK;
            strong_reg      <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg       <= phase_next;
            tick_reg        <= tick_next;
            bits_reg        <= bits_next;
            shift_reg       <= shift_next;
            last_status_reg <= last_status_next;
            strong_reg      <= strong_next;
        end
    end

    assign res.drive_low  = drv_low;
    assign res.drive_high = drv_high;
    assign res.busy_res   = phase_next != PH_IDLE;
    assign res.done_res   = done;
    assign res.read_data  = rd;
    assign res.status     = status_out;

endmodule

// File: rtl/one_wire_bus_master.sv
// ============================================================================
// one_wire_bus_master: 1-Wire bus master timed by microsecond ticks
// Input register, single-pass sequencer and result register.
// ============================================================================
// Each input item is either a tick (kind 0, or any unknown kind) carrying the
// line level sampled at the end of the elapsed tick interval, or a command:
// bus reset with presence check, LSB-first byte write, byte read or 16-bit
// word read. Every item yields exactly one result item giving the line drive
// for the next tick interval plus busy, done, read data and status. A command
// sent while another is running is rejected with status 3 and costs no time.
// The block takes one item per clock cycle unless the result side stalls: an
// item is captured in the input register, passes the sequencer logic and is
// registered in the result register, from which its result is offered on the
// master side. While a result waits for m_tready the input register
// takes one more item and then holds s_tready low until the result drains;
// from then on both sides move in the same cycle. The eight 12-bit timing
// registers sit on the APB port at byte addresses 0x00..0x1C; write them
// only while no command is running and no item is in flight.
module one_wire_bus_master (
    input  logic                       clk,
    input  logic                       rst_n,
    // slave side
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // line_level, data_byte[8:1], hold_high_after
    input  logic [2:0]                 s_tuser,   // kind
    // master side
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [23:0]                m_tdata,   // drive_low, drive_high, busy_res,
                                                  // done_res, read_data[19:4], status[21:20]
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [owm_pkg::ADDR_W-1:0] paddr,
    input  logic [owm_pkg::APB_W-1:0]  pwdata,
    output logic [owm_pkg::APB_W-1:0]  prdata,
    output logic                       pready
);

    owm_pkg::cfg_regs_t cfg;
    owm_pkg::item_t     in_item_reg;
    owm_pkg::item_t     in_item_next;
    owm_pkg::result_t   out_res_reg;
    owm_pkg::result_t   core_res;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               s_accept;

    assign pready = 1'b1;

    owm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Advance the held item whenever the result register is free or drains
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    // Unpack the incoming item
    assign in_item_next.kind            = s_tuser;
    assign in_item_next.line_level      = s_tdata[0];
    assign in_item_next.data_byte       = s_tdata[8:1];
    assign in_item_next.hold_high_after = s_tdata[9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= in_item_next;
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    owm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg.status, out_res_reg.read_data,
                       out_res_reg.done_res, out_res_reg.busy_res,
                       out_res_reg.drive_high, out_res_reg.drive_low};

endmodule

// File: rtl/owm_checker.sv
// ============================================================================
// owm_checker: port-level checks of the one-wire bus master
// Result stream consistency and output hold under back-pressure.
// ============================================================================
module owm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // A stalled result holds
    ast_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Pulling low happens only during a command
    ast_low_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[2] && !m_tdata[1])
        else $error("drive low outside a command");

    // A finished command leaves the master idle
    ast_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[2])
        else $error("done while still busy");

    // Rejection only while busy and never with done
    ast_reject: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[21:20] == 2'd3) |-> m_tdata[2] && !m_tdata[3])
        else $error("rejected status outside busy");

    // Read data shows only on a done result
    ast_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[3] |-> (m_tdata[19:4] == 16'h0000))
        else $error("read data without done");

endmodule

bind one_wire_bus_master owm_checker u_owm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
